// File: rtl/core/blt_pkg.sv
package blt_pkg;

    // Display size defaults
    localparam int DISPLAY_WIDTH_DEF  = 256;
    localparam int DISPLAY_HEIGHT_DEF = 256;

    // Field widths
    localparam int CORNER_W = 12;   // signed corner registers and offset counters
    localparam int COORD_W  = 11;   // on-screen column or row, display is at most 2048
    localparam int PIX_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Alpha field of the packed byte, always opaque
    localparam logic [1:0] ALPHA_OPAQUE = 2'b11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_LEFT     = 3'd0,
        CFG_AREA_TOP      = 3'd1,
        CFG_AREA_RIGHT    = 3'd2,
        CFG_AREA_BOTTOM   = 3'd3,
        CFG_AREA_IS_FINAL = 3'd4
    } t_cfg_idx;

    // One classified pixel handed from front to back
    typedef struct packed {
        logic               we;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [BYTE_W-1:0]  pix_byte;
        logic               area_done;
        logic               frame_done;
    } t_blt_item;

    // ABGR2222 from RGB565: top two bits of each channel
    function automatic logic [BYTE_W-1:0] pack_abgr2222(input logic [PIX_W-1:0] p);
        pack_abgr2222 = {ALPHA_OPAQUE, p[4:3], p[10:9], p[15:14]};
    endfunction

endpackage

// File: rtl/core/blt_front.sv
module blt_front #(
    parameter int DISPLAY_WIDTH  = blt_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = blt_pkg::DISPLAY_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [blt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [blt_pkg::CORNER_W-1:0]    i_cfg_data,
    input  logic                            i_accept,
    input  logic [blt_pkg::PIX_W-1:0]       i_pixel_rgb565,
    output blt_pkg::t_blt_item              o_item
);

    localparam int CW = blt_pkg::CORNER_W;
    localparam int PW = blt_pkg::CORNER_W + 2;   // screen position, signed

    logic signed [CW-1:0] r_left, r_top, r_right, r_bottom;
    logic                 r_is_final;
    logic [CW-1:0]        r_col_off, r_row_off;
    logic [CW-1:0]        n_col_off, n_row_off;

    logic                 empty;
    logic [CW-1:0]        last_col, last_row;
    logic signed [PW-1:0] pos_col, pos_row;
    logic                 visible;
    logic                 area_done;
    logic signed [CW:0]   span_col, span_row;

    assign empty    = (r_right < r_left) || (r_bottom < r_top);
    assign span_col = (CW+1)'(r_right) - (CW+1)'(r_left);
    assign span_row = (CW+1)'(r_bottom) - (CW+1)'(r_top);
    assign last_col = span_col[CW-1:0];
    assign last_row = span_row[CW-1:0];

    assign pos_col = PW'(r_left) + $signed({2'b00, r_col_off});
    assign pos_row = PW'(r_top)  + $signed({2'b00, r_row_off});

    assign visible = !empty
                  && !pos_col[PW-1] && (pos_col < $signed(PW'(DISPLAY_WIDTH)))
                  && !pos_row[PW-1] && (pos_row < $signed(PW'(DISPLAY_HEIGHT)));

    // Advance within the row, wrap to the next row, then to the area start
    always_comb begin
        n_col_off = r_col_off;
        n_row_off = r_row_off;
        area_done = 1'b0;
        if (empty) begin
            n_col_off = '0;
            n_row_off = '0;
            area_done = 1'b1;
        end else if (r_col_off >= last_col) begin
            n_col_off = '0;
            if (r_row_off >= last_row) begin
                n_row_off = '0;
                area_done = 1'b1;
            end else begin
                n_row_off = r_row_off + 1'b1;
            end
        end else begin
            n_col_off = r_col_off + 1'b1;
        end
    end

    always_comb begin
        o_item.we         = visible;
        o_item.row        = visible ? pos_row[blt_pkg::COORD_W-1:0] : '0;
        o_item.col        = visible ? pos_col[blt_pkg::COORD_W-1:0] : '0;
        o_item.pix_byte   = visible ? blt_pkg::pack_abgr2222(i_pixel_rgb565) : '0;
        o_item.area_done  = area_done;
        o_item.frame_done = area_done & r_is_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_top      <= '0;
            r_right    <= CW'(255);
            r_bottom   <= CW'(255);
            r_is_final <= 1'b0;
            r_col_off  <= '0;
            r_row_off  <= '0;
        end else if (i_cfg_we) begin
            unique case (blt_pkg::t_cfg_idx'(i_cfg_index))
                blt_pkg::CFG_AREA_LEFT: begin
                    r_left    <= i_cfg_data;
                    r_col_off <= '0;
                    r_row_off <= '0;
                end
                blt_pkg::CFG_AREA_TOP: begin
                    r_top     <= i_cfg_data;
                    r_col_off <= '0;
                    r_row_off <= '0;
                end
                blt_pkg::CFG_AREA_RIGHT: begin
                    r_right   <= i_cfg_data;
                    r_col_off <= '0;
                    r_row_off <= '0;
                end
                blt_pkg::CFG_AREA_BOTTOM: begin
                    r_bottom  <= i_cfg_data;
                    r_col_off <= '0;
                    r_row_off <= '0;
                end
                blt_pkg::CFG_AREA_IS_FINAL: begin
                    r_is_final <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            r_col_off <= n_col_off;
            r_row_off <= n_row_off;
        end
    end

    a_empty_holds_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty |-> (r_col_off == '0 && r_row_off == '0))
        else $error("offset counters off origin on an empty area");

    a_col_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_col_off <= last_col && r_row_off <= last_row))
        else $error("offset counter beyond area span");

endmodule

// File: rtl/core/blt_fifo.sv
module blt_fifo #(
    parameter int DEPTH = blt_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  blt_pkg::t_blt_item i_push_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_not_empty,
    output blt_pkg::t_blt_item o_pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blt_pkg::t_blt_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_pop_item  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("pop from an empty queue");

endmodule

// File: rtl/core/blt_back.sv
module blt_back #(
    parameter int DISPLAY_WIDTH = blt_pkg::DISPLAY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  blt_pkg::t_blt_item            i_item,
    output logic                          o_pop,
    output logic                          o_wr_valid,
    input  logic                          i_wr_ready,
    output logic                          o_write_enable,
    output logic [blt_pkg::ADDR_W-1:0]    o_write_address,
    output logic [blt_pkg::BYTE_W-1:0]    o_write_byte,
    output logic                          o_area_done,
    output logic                          o_frame_done
);

    localparam int CO = blt_pkg::COORD_W;
    localparam int MW = CO + 1;           // width constant, up to 2048
    localparam int PRW = CO + MW;
    localparam int SW = PRW + 1;

    localparam logic [MW-1:0] WIDTH_K = MW'(DISPLAY_WIDTH);

    logic                         r_valid;
    logic                         r_we;
    logic [blt_pkg::ADDR_W-1:0]   r_addr;
    logic [blt_pkg::BYTE_W-1:0]   r_byte;
    logic                         r_area_done;
    logic                         r_frame_done;

    logic [PRW-1:0] product;
    logic [SW-1:0]  lin_addr;

    assign product  = PRW'(i_item.row) * PRW'(WIDTH_K);
    assign lin_addr = SW'(product) + SW'(i_item.col);

    // Take the next beat whenever the output register is free or draining
    assign o_pop = i_item_valid && (!r_valid || i_wr_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_wr_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_we         <= i_item.we;
            r_addr       <= i_item.we ? lin_addr[blt_pkg::ADDR_W-1:0] : '0;
            r_byte       <= i_item.pix_byte;
            r_area_done  <= i_item.area_done;
            r_frame_done <= i_item.frame_done;
        end
    end

    assign o_wr_valid      = r_valid;
    assign o_write_enable  = r_we;
    assign o_write_address = r_addr;
    assign o_write_byte    = r_byte;
    assign o_area_done     = r_area_done;
    assign o_frame_done    = r_frame_done;

    a_frame_implies_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_frame_done |-> r_area_done)
        else $error("frame end without area end");

endmodule

// File: rtl/core/clipped_rgb565_to_abgr2222_blit.sv
// Clipped RGB565 to ABGR2222 blit. Send the RGB565 pixels of one rectangular
// area in row-major order, one beat per pixel; the area corners (left, top,
// right, bottom, inclusive, signed 12 bit) and the final-area flag are set
// through the write port, by the user only while the block is idle, which the
// block does not enforce, and writing any corner restarts the area at its
// first pixel. Every input beat yields exactly one output beat: write_enable
// is high when the pixel lands on the display, with write_address = row *
// DISPLAY_WIDTH + column (low 16 bits) and an ABGR2222 byte with alpha fixed
// at 3; off-screen pixels come out with enable, address and byte all zero.
// area_done marks the last pixel of the area, frame_done the same pixel when
// the area is flagged final; an empty area (right < left or bottom < top)
// flags area_done on every beat. The front stage counts column and row and
// clips each pixel in the accepting cycle, a two-entry queue decouples it
// from the back stage, which forms the address with one small multiply into
// the output register. Throughput is one pixel per clock; input ready drops
// only when the queue is full because the output side is stalled.
module clipped_rgb565_to_abgr2222_blit #(
    parameter int DISPLAY_WIDTH  = blt_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = blt_pkg::DISPLAY_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [blt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [blt_pkg::CORNER_W-1:0]  i_cfg_data,
    // pixel input
    input  logic                          i_pix_valid,
    output logic                          o_pix_ready,
    input  logic [blt_pkg::PIX_W-1:0]     i_pixel_rgb565,
    // frame-buffer write output
    output logic                          o_wr_valid,
    input  logic                          i_wr_ready,
    output logic                          o_write_enable,
    output logic [blt_pkg::ADDR_W-1:0]    o_write_address,
    output logic [blt_pkg::BYTE_W-1:0]    o_write_byte,
    output logic                          o_area_done,
    output logic                          o_frame_done
);

    logic               pix_accept;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;
    blt_pkg::t_blt_item front_item;
    blt_pkg::t_blt_item back_item;

    // Accept a beat whenever the queue has room
    assign o_pix_ready = !q_full;
    assign pix_accept  = i_pix_valid && o_pix_ready;

    // Front: hold corners, count offsets, clip and pack
    blt_front #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (pix_accept),
        .i_pixel_rgb565 (i_pixel_rgb565),
        .o_item         (front_item)
    );

    // Queue: lets the front keep taking beats while the output stalls
    blt_fifo #(
        .DEPTH (blt_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (pix_accept),
        .i_push_item (front_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_pop_item  (back_item)
    );

    // Back: form the linear address and drive the output register
    blt_back #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (q_not_empty),
        .i_item          (back_item),
        .o_pop           (q_pop),
        .o_wr_valid      (o_wr_valid),
        .i_wr_ready      (i_wr_ready),
        .o_write_enable  (o_write_enable),
        .o_write_address (o_write_address),
        .o_write_byte    (o_write_byte),
        .o_area_done     (o_area_done),
        .o_frame_done    (o_frame_done)
    );

endmodule

// File: verif/clipped_rgb565_to_abgr2222_blit_test.sv
module clipped_rgb565_to_abgr2222_blit_test;
    import blt_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int DISP_W     = DISPLAY_WIDTH_DEF;
    localparam int DISP_H     = DISPLAY_HEIGHT_DEF;

    // Indexes past the last register; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam int RANDOM_PIXELS = 500;
    localparam int PHASES        = 4;
    localparam int DRAIN_CYCLES  = 20;

    // One frame-buffer write beat as it leaves the block
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [BYTE_W-1:0] write_byte;
        logic              area_done;
        logic              frame_done;
    } fb_write_t;

    // One row of the directed table: a register write or a pixel beat,
    // the latter optionally with its result spelled out by hand
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CORNER_W-1:0]  data;
        logic [PIX_W-1:0]     pix;
        bit                   typed;
        fb_write_t            want;
    } stim_row_t;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CORNER_W-1:0]  i_cfg_data     = '0;
    logic                 i_pix_valid    = 1'b0;
    logic [PIX_W-1:0]     i_pixel_rgb565 = '0;
    logic                 i_wr_ready     = 1'b0;
    logic                 o_pix_ready;
    logic                 o_wr_valid;
    logic                 o_write_enable;
    logic [ADDR_W-1:0]    o_write_address;
    logic [BYTE_W-1:0]    o_write_byte;
    logic                 o_area_done;
    logic                 o_frame_done;

    // Shadow of the block: corner registers, final flag and area counters
    logic signed [CORNER_W-1:0] mdl_left   = 12'sd0;
    logic signed [CORNER_W-1:0] mdl_top    = 12'sd0;
    logic signed [CORNER_W-1:0] mdl_right  = 12'sd255;
    logic signed [CORNER_W-1:0] mdl_bottom = 12'sd255;
    logic                       mdl_final  = 1'b0;
    logic [CORNER_W-1:0]        col_off    = '0;
    logic [CORNER_W-1:0]        row_off    = '0;

    // Write beats owed by the block, oldest first
    fb_write_t pending_writes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int pixels_sent    = 0;
    int visible_seen   = 0;
    int areas_seen     = 0;
    int frames_seen    = 0;
    int cfg_writes     = 0;

    clipped_rgb565_to_abgr2222_blit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pix_valid    (i_pix_valid),
        .o_pix_ready    (o_pix_ready),
        .i_pixel_rgb565 (i_pixel_rgb565),
        .o_wr_valid     (o_wr_valid),
        .i_wr_ready     (i_wr_ready),
        .o_write_enable (o_write_enable),
        .o_write_address(o_write_address),
        .o_write_byte   (o_write_byte),
        .o_area_done    (o_area_done),
        .o_frame_done   (o_frame_done)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic fb_write_t fb_write(input logic we, input logic [ADDR_W-1:0] addr,
                                           input logic [BYTE_W-1:0] b, input logic ad,
                                           input logic fd);
        fb_write = '{we, addr, b, ad, fd};
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CORNER_W-1:0] data);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic stim_row_t pix_row(input logic [PIX_W-1:0] pix, input bit typed,
                                          input fb_write_t want);
        stim_row_t r;
        r = '{default: '0};
        r.pix   = pix;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Work out the write beat for one pixel and advance the area counters.
    // Corners are signed; the offsets are unsigned 12-bit counters.
    function automatic fb_write_t predict_fb_write(input logic [PIX_W-1:0] pix);
        fb_write_t w;
        int col;
        int row;
        w = '0;
        if (mdl_right < mdl_left || mdl_bottom < mdl_top) begin
            // Empty area: nothing visible, every beat ends the area
            col_off     = '0;
            row_off     = '0;
            w.area_done = 1'b1;
        end else begin
            col = int'(mdl_left) + int'(col_off);
            row = int'(mdl_top) + int'(row_off);
            // Clip against the display; off-screen beats carry zero payload
            if (col >= 0 && col < DISP_W && row >= 0 && row < DISP_H) begin
                w.write_enable  = 1'b1;
                w.write_address = ADDR_W'(row * DISP_W + col);
                w.write_byte    = {ALPHA_OPAQUE, pix[4:3], pix[10:9], pix[15:14]};
            end
            // Advance column, then row, wrapping at the area's last pixel
            if (int'(col_off) >= int'(mdl_right) - int'(mdl_left)) begin
                col_off = '0;
                if (int'(row_off) >= int'(mdl_bottom) - int'(mdl_top)) begin
                    row_off     = '0;
                    w.area_done = 1'b1;
                end else begin
                    row_off = row_off + 1'b1;
                end
            end else begin
                col_off = col_off + 1'b1;
            end
        end
        w.frame_done = w.area_done & mdl_final;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Hold the pixel channel low and wait until every owed beat has come out
    task automatic drain();
        i_pix_valid = 1'b0;
        while (pending_writes.size() != 0) @(negedge i_clk);
    endtask

    // Write one register for a single cycle and mirror it in the shadow.
    // Call only at a falling edge with the block drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CORNER_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_AREA_LEFT:     mdl_left   = data;
            CFG_AREA_TOP:      mdl_top    = data;
            CFG_AREA_RIGHT:    mdl_right  = data;
            CFG_AREA_BOTTOM:   mdl_bottom = data;
            CFG_AREA_IS_FINAL: mdl_final  = data[0];
            default: ;
        endcase
        // Any corner restarts the area; the final flag and spare indexes do not
        if (idx <= CFG_AREA_BOTTOM) begin
            col_off = '0;
            row_off = '0;
        end
        cfg_writes++;
    endtask

    // Offer one pixel beat after a random idle gap, hold it until accepted,
    // and queue the write beat it owes. Returns at the next falling edge.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                              input fb_write_t want);
        fb_write_t w;
        while ($urandom_range(99) < send_idle_pct) begin
            i_pix_valid = 1'b0;
            @(negedge i_clk);
        end
        i_pix_valid    = 1'b1;
        i_pixel_rgb565 = pix;
        do @(posedge i_clk); while (!o_pix_ready);
        w = predict_fb_write(pix);
        pending_writes.push_back(typed ? want : w);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Receiver back-pressure: redraw ready every falling edge
    always @(negedge i_clk) i_wr_ready = ($urandom_range(99) >= recv_stall_pct);

    // Compare each accepted write beat against the oldest owed one
    always @(posedge i_clk) begin
        fb_write_t got;
        fb_write_t want;
        if (i_rst_n && o_wr_valid && i_wr_ready) begin
            got = '{o_write_enable, o_write_address, o_write_byte, o_area_done, o_frame_done};
            if (pending_writes.size() == 0) begin
                $error("write beat with nothing owed: 0x%0h", got);
                errors++;
            end else begin
                want = pending_writes.pop_front();
                check_field("write_enable", want.write_enable, got.write_enable);
                check_field("write_address", want.write_address, got.write_address);
                check_field("write_byte", want.write_byte, got.write_byte);
                check_field("area_done", want.area_done, got.area_done);
                check_field("frame_done", want.frame_done, got.frame_done);
                if (got.write_enable) visible_seen++;
                if (got.area_done) areas_seen++;
                if (got.frame_done) frames_seen++;
            end
        end
    end

    initial begin
        stim_row_t directed[$];
        int        send_tbl[PHASES];
        int        recv_tbl[PHASES];
        int        phase_start;
        int        sel;
        int        l;
        int        t;
        int        r;
        int        b;
        int        size;
        int        count;

        send_tbl = '{0, 51, 0, 28};
        recv_tbl = '{0, 0, 51, 28};

        // Hold reset, then release it at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset area 0..255 square: first pixels land at addresses 0 and 1
        directed.push_back(pix_row(16'h0000, 1, fb_write(1, 16'h0000, 8'hC0, 0, 0)));
        directed.push_back(pix_row(16'hFFFF, 1, fb_write(1, 16'h0001, 8'hFF, 0, 0)));
        directed.push_back(pix_row(16'h4208, 0, '0));
        directed.push_back(pix_row(16'h8410, 0, '0));
        // Two-by-two area hanging off the left and bottom edges
        directed.push_back(cfg_row(CFG_AREA_LEFT, 12'hFFF));
        directed.push_back(cfg_row(CFG_AREA_TOP, 12'h0FF));
        directed.push_back(cfg_row(CFG_AREA_RIGHT, 12'h000));
        directed.push_back(cfg_row(CFG_AREA_BOTTOM, 12'h100));
        directed.push_back(pix_row(16'h8000, 1, fb_write(0, 16'h0000, 8'h00, 0, 0)));
        directed.push_back(pix_row(16'h8000, 1, fb_write(1, 16'hFF00, 8'hC2, 0, 0)));
        directed.push_back(pix_row(16'hFFFF, 1, fb_write(0, 16'h0000, 8'h00, 0, 0)));
        directed.push_back(pix_row(16'hFFFF, 1, fb_write(0, 16'h0000, 8'h00, 1, 0)));
        // Same area again, now marked as the last flush of the frame
        directed.push_back(cfg_row(CFG_AREA_IS_FINAL, 12'h001));
        directed.push_back(pix_row(16'h1234, 0, '0));
        directed.push_back(pix_row(16'hABCD, 0, '0));
        directed.push_back(pix_row(16'h5555, 0, '0));
        directed.push_back(pix_row(16'hAAAA, 0, '0));
        // Single pixel at the most negative corner, off screen
        directed.push_back(cfg_row(CFG_AREA_LEFT, 12'h800));
        directed.push_back(cfg_row(CFG_AREA_TOP, 12'h800));
        directed.push_back(cfg_row(CFG_AREA_RIGHT, 12'h800));
        directed.push_back(cfg_row(CFG_AREA_BOTTOM, 12'h800));
        directed.push_back(pix_row(16'hFFFF, 1, fb_write(0, 16'h0000, 8'h00, 1, 1)));
        directed.push_back(pix_row(16'h0000, 1, fb_write(0, 16'h0000, 8'h00, 1, 1)));
        // Single pixel at the most positive corner, off screen
        directed.push_back(cfg_row(CFG_AREA_LEFT, 12'h7FF));
        directed.push_back(cfg_row(CFG_AREA_TOP, 12'h7FF));
        directed.push_back(cfg_row(CFG_AREA_RIGHT, 12'h7FF));
        directed.push_back(cfg_row(CFG_AREA_BOTTOM, 12'h7FF));
        directed.push_back(pix_row(16'hFFFF, 1, fb_write(0, 16'h0000, 8'h00, 1, 1)));
        // Bottom-right screen pixel: top of the address range
        directed.push_back(cfg_row(CFG_AREA_LEFT, 12'h0FF));
        directed.push_back(cfg_row(CFG_AREA_TOP, 12'h0FF));
        directed.push_back(cfg_row(CFG_AREA_RIGHT, 12'h0FF));
        directed.push_back(cfg_row(CFG_AREA_BOTTOM, 12'h0FF));
        directed.push_back(pix_row(16'hFFFF, 1, fb_write(1, 16'hFFFF, 8'hFF, 1, 1)));
        // Empty area, right left of left: every beat ends the area
        directed.push_back(cfg_row(CFG_AREA_LEFT, 12'h00A));
        directed.push_back(cfg_row(CFG_AREA_RIGHT, 12'h009));
        directed.push_back(pix_row(16'h1234, 1, fb_write(0, 16'h0000, 8'h00, 1, 1)));
        directed.push_back(pix_row(16'hFEDC, 1, fb_write(0, 16'h0000, 8'h00, 1, 1)));
        // Spare indexes and the final flag mid-area must not restart the count
        directed.push_back(cfg_row(CFG_AREA_LEFT, 12'h000));
        directed.push_back(cfg_row(CFG_AREA_TOP, 12'h000));
        directed.push_back(cfg_row(CFG_AREA_RIGHT, 12'h001));
        directed.push_back(cfg_row(CFG_AREA_BOTTOM, 12'h000));
        directed.push_back(pix_row(16'h0618, 0, '0));
        directed.push_back(cfg_row(CFG_SPARE_LAST, 12'hFFF));
        directed.push_back(cfg_row(CFG_AREA_IS_FINAL, 12'hFFE));
        directed.push_back(pix_row(16'hF9E7, 0, '0));
        directed.push_back(cfg_row(CFG_SPARE_FIRST, 12'h000));
        directed.push_back(cfg_row(CFG_SPARE_FIRST + 3'd1, 12'h555));
        directed.push_back(pix_row(16'h7BEF, 0, '0));

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                drain();
                write_reg(directed[k].idx, directed[k].data);
            end else begin
                send_pixel(directed[k].pix, directed[k].typed, directed[k].want);
            end
        end

        // Random areas under each idling mix. Most areas are small, sit anywhere
        // on the screen or just past its edges and are sent whole, sometimes twice;
        // some get cut short by the next reconfiguration. The rest use arbitrary
        // corners, which gives empty areas and huge mostly off-screen ones.
        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct  = send_tbl[p];
            recv_stall_pct = recv_tbl[p];
            phase_start    = pixels_sent;
            while (pixels_sent - phase_start < RANDOM_PIXELS / PHASES) begin
                drain();
                sel = $urandom_range(99);
                if (sel < 80) begin
                    l = int'($urandom_range(270)) - 10;
                    t = int'($urandom_range(270)) - 10;
                    r = l + int'($urandom_range(1, 8)) - 1;
                    b = t + int'($urandom_range(1, 6)) - 1;
                end else begin
                    l = int'($urandom_range(4095)) - 2048;
                    t = int'($urandom_range(4095)) - 2048;
                    r = int'($urandom_range(4095)) - 2048;
                    b = int'($urandom_range(4095)) - 2048;
                end
                write_reg(CFG_AREA_LEFT, CORNER_W'(l));
                write_reg(CFG_AREA_TOP, CORNER_W'(t));
                write_reg(CFG_AREA_RIGHT, CORNER_W'(r));
                write_reg(CFG_AREA_BOTTOM, CORNER_W'(b));
                if ($urandom_range(1) == 0) write_reg(CFG_AREA_IS_FINAL, CORNER_W'($urandom));
                if ($urandom_range(9) == 0) begin
                    write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                              CORNER_W'($urandom));
                end

                size = (r < l || b < t) ? 0 : (r - l + 1) * (b - t + 1);
                if (size == 0) begin
                    count = $urandom_range(1, 3);
                end else if (size <= 48) begin
                    count = size * int'($urandom_range(1, 2));
                    if ($urandom_range(3) == 0) count += int'($urandom_range(1, size));
                end else begin
                    count = $urandom_range(1, 24);
                end

                for (int k = 0; k < count; k++) begin
                    // Now and then stop sending until the block has emptied
                    if ($urandom_range(49) == 0) drain();
                    send_pixel(PIX_W'($urandom), 0, '0);
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_writes.size() != 0) begin
            $error("%0d write beats never arrived", pending_writes.size());
            errors++;
        end

        $display("covered %0d pixel beats and %0d register writes over four idling mixes,",
                 pixels_sent, cfg_writes);
        $display("with %0d visible writes, %0d area ends and %0d frame ends",
                 visible_seen, areas_seen, frames_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #(CLK_PERIOD * 200000);
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/blt_pkg.sv
rtl/core/blt_front.sv
rtl/core/blt_fifo.sv
rtl/core/blt_back.sv
rtl/core/clipped_rgb565_to_abgr2222_blit.sv
verif/clipped_rgb565_to_abgr2222_blit_test.sv
